// ----- sv/ttam_pkg.sv -----
// ----------------------------------------------------------------------------
// ttam_pkg
// Shared types, codes and helpers for the tiled texture address map.
// ----------------------------------------------------------------------------
package ttam_pkg;

  localparam int IDX_W      = 22;
  localparam int CFG_DATA_W = 11;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_DIRECTION    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH        = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT       = 2'd3;

  localparam logic DIR_UNSWIZZLE = 1'b0;
  localparam logic DIR_SWIZZLE   = 1'b1;

  localparam logic [1:0] FMT_4BPP  = 2'd0;
  localparam logic [1:0] FMT_8BPP  = 2'd1;
  localparam logic [1:0] FMT_16BPP = 2'd2;
  localparam logic [1:0] FMT_32BPP = 2'd3;

  localparam logic [CFG_DATA_W-1:0] RESET_SIDE = 11'd1024;

  // 16-bit word order inside a 16-byte linear group for 32 bpp.
  localparam logic [2:0] WORD_PERM [8] = '{3'd4, 3'd0, 3'd5, 3'd1,
                                           3'd6, 3'd2, 3'd7, 3'd3};

  typedef struct packed {
    logic       direction;
    logic [1:0] pixel_format;
  } ttam_mode_t;

  typedef struct packed {
    logic       out_of_range;
    logic       no_source;
    logic [4:0] low5;
  } ttam_side_t;

  // Width helpers, all derived from the largest supported side.
  function automatic int side_w(input int max_side);
    return $clog2(max_side + 1);
  endfunction

  function automatic int wb_w(input int max_side);
    return side_w(max_side) + 2;
  endfunction

  function automatic int bw_w(input int max_side);
    return $clog2(((4 * max_side + 7) >> 3) + 1);
  endfunction

  function automatic int rs_w(input int max_side);
    return $clog2(4 * max_side + 8);
  endfunction

  function automatic int rp_w(input int max_side);
    return $clog2(max_side + 8);
  endfunction

  // Low four bits of a permuted linear position when unswizzling 32 bpp.
  function automatic logic [3:0] unswz_low(input logic [3:0] lo);
    return {WORD_PERM[lo[3:1]], ~lo[0]};
  endfunction

  // Low six bits of a permuted tiled position when swizzling 32 bpp.
  function automatic logic [5:0] swz_low(input logic [5:0] lo);
    logic       half;
    logic [1:0] j;
    logic [2:0] m;
    logic [4:0] sh;
    half = lo[5];
    j    = lo[4:3];
    m    = {lo[2:1], ~half};
    if (!m[2]) begin
      sh = {1'b0, j, m[1:0]};
    end else begin
      sh = 5'd12 + {1'b0, j, 2'b00} + {2'b00, m};
    end
    return {sh, ~lo[0]};
  endfunction

endpackage

// ----- sv/ttam_cfg.sv -----
// ----------------------------------------------------------------------------
// ttam_cfg
// Configuration registers and the registered texture geometry.
// ----------------------------------------------------------------------------
module ttam_cfg #(
  parameter int MAX_SIDE = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [ttam_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [ttam_pkg::CFG_DATA_W-1:0]      cfg_data,
  output ttam_pkg::ttam_mode_t                 mode,
  output logic [ttam_pkg::side_w(MAX_SIDE)-1:0] h,
  output logic [ttam_pkg::wb_w(MAX_SIDE)-1:0]   wb,
  output logic [ttam_pkg::bw_w(MAX_SIDE)-1:0]   bw,
  output logic [ttam_pkg::rs_w(MAX_SIDE)-1:0]   row_size,
  output logic [ttam_pkg::rp_w(MAX_SIDE) + ttam_pkg::rs_w(MAX_SIDE)-1:0] total,
  output logic [2*ttam_pkg::side_w(MAX_SIDE)-1:0] pixels
);
  import ttam_pkg::*;

  localparam int SIDE_W = side_w(MAX_SIDE);
  localparam int WB_W   = wb_w(MAX_SIDE);
  localparam int BW_W   = bw_w(MAX_SIDE);
  localparam int RS_W   = rs_w(MAX_SIDE);
  localparam int RP_W   = rp_w(MAX_SIDE);
  localparam int TOT_W  = RP_W + RS_W;
  localparam int PIX_W  = 2 * SIDE_W;

  logic                  direction;
  logic [1:0]            pixel_format;
  logic [CFG_DATA_W-1:0] width_pixels;
  logic [CFG_DATA_W-1:0] height_pixels;

  logic              fmt0;
  logic [SIDE_W-1:0] w_cl;
  logic [SIDE_W-1:0] h_cl;
  logic [WB_W-1:0]   wb_c;
  logic [WB_W:0]     wb_up;
  logic [BW_W-1:0]   bw_c;
  logic [RS_W-1:0]   rs_c;
  logic [SIDE_W:0]   h_up;
  logic [RP_W-1:0]   rp_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction     <= DIR_UNSWIZZLE;
      pixel_format  <= FMT_8BPP;
      width_pixels  <= RESET_SIDE;
      height_pixels <= RESET_SIDE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DIRECTION:    direction     <= cfg_data[0];
        REG_PIXEL_FORMAT: pixel_format  <= cfg_data[1:0];
        REG_WIDTH:        width_pixels  <= cfg_data;
        REG_HEIGHT:       height_pixels <= cfg_data;
      endcase
    end
  end

  assign fmt0 = (pixel_format == FMT_4BPP);
  assign w_cl = (32'(width_pixels) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : SIDE_W'(width_pixels);
  assign h_cl = (32'(height_pixels) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : SIDE_W'(height_pixels);

  always_comb begin
    unique case (pixel_format)
      FMT_4BPP:  wb_c = WB_W'(w_cl >> 1);
      FMT_8BPP:  wb_c = WB_W'(w_cl);
      FMT_16BPP: wb_c = WB_W'({w_cl, 1'b0});
      FMT_32BPP: wb_c = WB_W'({w_cl, 2'b00});
    endcase
  end

  // Blocks are four bytes wide in 4 bpp and eight bytes wide otherwise.
  assign wb_up = {1'b0, wb_c} + (fmt0 ? (WB_W+1)'(3) : (WB_W+1)'(7));
  assign bw_c  = fmt0 ? BW_W'(wb_up >> 2) : BW_W'(wb_up >> 3);
  assign rs_c  = fmt0 ? RS_W'({bw_c, 2'b00}) : RS_W'({bw_c, 3'b000});
  assign h_up  = {1'b0, h_cl} + (fmt0 ? (SIDE_W+1)'(7) : (SIDE_W+1)'(3));
  assign rp_c  = fmt0 ? RP_W'({h_up[SIDE_W:3], 3'b000}) : RP_W'({h_up[SIDE_W:2], 2'b00});

  always_ff @(posedge clk) begin
    mode     <= '{direction: direction, pixel_format: pixel_format};
    h        <= h_cl;
    wb       <= wb_c;
    bw       <= bw_c;
    row_size <= rs_c;
    total    <= TOT_W'(rp_c) * TOT_W'(rs_c);
    pixels   <= PIX_W'(w_cl) * PIX_W'(h_cl);
  end

endmodule

// ----- sv/ttam_front.sv -----
// ----------------------------------------------------------------------------
// ttam_front
// Input register, range check, 32 bpp word permutation and divider operand.
// ----------------------------------------------------------------------------
module ttam_front #(
  parameter int MAX_SIDE = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [ttam_pkg::IDX_W-1:0]            dest_index,
  input  ttam_pkg::ttam_mode_t                  mode,
  input  logic [ttam_pkg::rp_w(MAX_SIDE) + ttam_pkg::rs_w(MAX_SIDE)-1:0] total,
  input  logic [2*ttam_pkg::side_w(MAX_SIDE)-1:0] pixels,
  output logic                                  out_valid,
  input  logic                                  dn_ready,
  output logic [ttam_pkg::IDX_W-1:0]            numer,
  output ttam_pkg::ttam_side_t                  side
);
  import ttam_pkg::*;

  logic             v0;
  logic [IDX_W-1:0] d0;
  logic             v1;
  logic             en0;
  logic             en1;

  logic             fmt0;
  logic             fmt3;
  logic             swz;
  logic             perm_u;
  logic             perm_s;
  logic [IDX_W-1:0] p_c;
  logic [IDX_W-1:0] numer_c;
  logic             oor_c;
  logic             beyond_c;

  assign en1      = !v1 || dn_ready;
  assign en0      = !v0 || en1;
  assign in_ready = en0;

  assign fmt0 = (mode.pixel_format == FMT_4BPP);
  assign fmt3 = (mode.pixel_format == FMT_32BPP);
  assign swz  = (mode.direction == DIR_SWIZZLE);

  // The permutation covers whole groups up to the last one touching a pixel:
  // group g is inside when g times the group's pixel count is below w*h.
  assign perm_u = fmt3 && !swz &&
                  (32'({d0[IDX_W-1:4], 2'b00}) < 32'(pixels));
  assign perm_s = fmt3 && swz &&
                  (32'({d0[IDX_W-1:6], 4'b0000}) < 32'(pixels));

  always_comb begin
    if (perm_u) begin
      p_c = {d0[IDX_W-1:4], unswz_low(d0[3:0])};
    end else if (perm_s) begin
      p_c = {d0[IDX_W-1:6], swz_low(d0[5:0])};
    end else begin
      p_c = d0;
    end
  end

  assign oor_c    = 32'(d0) >= 32'(total);
  assign beyond_c = 32'(p_c) >= 32'(total);

  // Both directions end in a division by the block count of one row.
  always_comb begin
    if (swz) begin
      numer_c = p_c >> 5;
    end else if (fmt0) begin
      numer_c = p_c >> 2;
    end else begin
      numer_c = p_c >> 3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      if (en0) v0 <= in_valid;
      if (en1) v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en0 && in_valid) d0 <= dest_index;
    if (en1) begin
      numer <= numer_c;
      side  <= '{out_of_range: oor_c, no_source: beyond_c, low5: p_c[4:0]};
    end
  end

  assign out_valid = v1;

endmodule

// ----- sv/ttam_div.sv -----
// ----------------------------------------------------------------------------
// ttam_div
// Pipelined restoring divider by the row block count, one quotient bit a
// stage.
// ----------------------------------------------------------------------------
module ttam_div #(
  parameter int MAX_SIDE = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [ttam_pkg::IDX_W-1:0]           numer,
  input  ttam_pkg::ttam_side_t                 side_in,
  input  logic [ttam_pkg::bw_w(MAX_SIDE)-1:0]  bw,
  output logic                                 out_valid,
  input  logic                                 dn_ready,
  output logic [ttam_pkg::rp_w(MAX_SIDE)-1:0]  quo,
  output logic [ttam_pkg::bw_w(MAX_SIDE)-1:0]  rem,
  output ttam_pkg::ttam_side_t                 side_out
);
  import ttam_pkg::*;

  localparam int BW_W = bw_w(MAX_SIDE);
  localparam int QW   = rp_w(MAX_SIDE);
  localparam int DW   = (IDX_W > BW_W + QW) ? IDX_W : BW_W + QW;

  logic [DW-1:0] rem_r  [QW];
  logic [QW-1:0] quo_r  [QW];
  ttam_side_t    side_r [QW];
  logic          v_r    [QW];
  logic          en     [QW];

  logic [DW-1:0] rem_i  [QW];
  logic [QW-1:0] quo_i  [QW];
  ttam_side_t    side_i [QW];
  logic          v_i    [QW];
  logic [DW-1:0] trial  [QW];
  logic          fits   [QW];

  // The quotient is known to fit in QW bits whenever the position lies
  // inside the image; other items are flagged and their result is dropped.
  always_comb begin
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        rem_i[k]  = DW'(numer);
        quo_i[k]  = '0;
        side_i[k] = side_in;
        v_i[k]    = in_valid;
      end else begin
        rem_i[k]  = rem_r[k-1];
        quo_i[k]  = quo_r[k-1];
        side_i[k] = side_r[k-1];
        v_i[k]    = v_r[k-1];
      end
      trial[k] = DW'(bw) << (QW - 1 - k);
      fits[k]  = rem_i[k] >= trial[k];
    end
  end

  always_comb begin
    en[QW-1] = !v_r[QW-1] || dn_ready;
    for (int k = QW - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QW; k++) begin
      if (rst) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= v_i[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QW; k++) begin
      if (en[k]) begin
        rem_r[k]  <= fits[k] ? rem_i[k] - trial[k] : rem_i[k];
        quo_r[k]  <= quo_i[k] | (QW'(fits[k]) << (QW - 1 - k));
        side_r[k] <= side_i[k];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[QW-1];
  assign quo       = quo_r[QW-1];
  assign rem       = BW_W'(rem_r[QW-1]);
  assign side_out  = side_r[QW-1];

endmodule

// ----- sv/ttam_back.sv -----
// ----------------------------------------------------------------------------
// ttam_back
// Padding check, address rebuild by one multiply and add, output register.
// ----------------------------------------------------------------------------
module ttam_back #(
  parameter int MAX_SIDE = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [ttam_pkg::rp_w(MAX_SIDE)-1:0]   quo,
  input  logic [ttam_pkg::bw_w(MAX_SIDE)-1:0]   rem,
  input  ttam_pkg::ttam_side_t                  side,
  input  ttam_pkg::ttam_mode_t                  mode,
  input  logic [ttam_pkg::side_w(MAX_SIDE)-1:0] h,
  input  logic [ttam_pkg::wb_w(MAX_SIDE)-1:0]   wb,
  input  logic [ttam_pkg::bw_w(MAX_SIDE)-1:0]   bw,
  input  logic [ttam_pkg::rs_w(MAX_SIDE)-1:0]   row_size,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [ttam_pkg::IDX_W-1:0]            source_index,
  output logic                                  no_source,
  output logic                                  out_of_range
);
  import ttam_pkg::*;

  localparam int BW_W = bw_w(MAX_SIDE);
  localparam int RS_W = rs_w(MAX_SIDE);
  localparam int QW   = rp_w(MAX_SIDE);
  localparam int RW   = QW + 3;
  localparam int CLW  = BW_W + 3;
  localparam int PW   = RW + RS_W;
  localparam int FW   = (PW + 6 > IDX_W) ? PW + 6 : IDX_W;

  logic v1;
  logic v2;
  logic en1;
  logic en2;

  logic [PW-1:0]  prod1;
  logic [CLW-1:0] add1;
  logic [4:0]     low1;
  logic           oor1;
  logic           nosrc1;

  logic           fmt0;
  logic           swz;
  logic [CLW-1:0] col_c;
  logic [RW-1:0]  row_s;
  logic [RW-1:0]  row_c;
  logic [RW-1:0]  by_u;
  logic [4:0]     low_u;
  logic           pad_c;
  logic [RW-1:0]  mul_a;
  logic [RS_W-1:0] mul_b;
  logic [FW-1:0]  sum_c;
  logic [FW-1:0]  res_c;

  assign en2      = !v2 || out_ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  assign fmt0 = (mode.pixel_format == FMT_4BPP);
  assign swz  = (mode.direction == DIR_SWIZZLE);

  // Column of the byte: the remainder counts whole blocks, the low bits of
  // the position give the byte inside the block.
  assign col_c = fmt0 ? CLW'({rem, side.low5[1:0]}) : CLW'({rem, side.low5[2:0]});

  // Swizzling: the quotient is the block row, the row inside the block
  // comes from the position. Unswizzling: the quotient is the image row.
  assign row_s = fmt0 ? RW'({quo, side.low5[4:2]}) : RW'({quo, side.low5[4:3]});
  assign row_c = swz ? row_s : RW'(quo);
  assign by_u  = fmt0 ? RW'(quo >> 3) : RW'(quo >> 2);
  assign low_u = fmt0 ? {quo[2:0], side.low5[1:0]} : {quo[1:0], side.low5[2:0]};

  assign pad_c = (32'(row_c) >= 32'(h)) || (32'(col_c) >= 32'(wb));
  assign mul_a = swz ? row_s : by_u;
  assign mul_b = swz ? row_size : RS_W'(bw);

  // A block holds 32 bytes in every format, so the tiled address is the
  // block number shifted by five with the in-block offset below it.
  assign sum_c = FW'(prod1) + FW'(add1);
  assign res_c = swz ? sum_c : {sum_c[FW-6:0], low1};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      prod1  <= PW'(mul_a) * PW'(mul_b);
      add1   <= swz ? col_c : CLW'(rem);
      low1   <= low_u;
      oor1   <= side.out_of_range;
      nosrc1 <= side.no_source || pad_c;
    end
    if (en2) begin
      source_index <= (oor1 || nosrc1) ? '0 : res_c[IDX_W-1:0];
      no_source    <= !oor1 && nosrc1;
      out_of_range <= oor1;
    end
  end

  assign out_valid = v2;

endmodule

// ----- sv/tiled_texture_address_map_core.sv -----
// ----------------------------------------------------------------------------
// tiled_texture_address_map_core
// Gather address generator between linear and block-tiled texture layouts.
// ----------------------------------------------------------------------------
//  Port group  Handshake              Carries
//  input       in_valid / in_ready    dest_index
//  output      out_valid / out_ready  source_index, no_source, out_of_range
//  config      cfg_write              cfg_index, cfg_data (no read-back)
//
//  One item is taken per clock while the output is not stalled with every
//  stage full. The item passes rp_w(MAX_SIDE) + 4 register stages; the
//  divider resolves one quotient bit per stage. Reset returns the
//  configuration to its defaults and clears all stage valid bits; the
//  geometry registers follow the configuration in the cycle after. A stall
//  at the output holds only the full stages; empty stages keep filling.
// ----------------------------------------------------------------------------
module tiled_texture_address_map_core #(
  parameter int MAX_SIDE = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [ttam_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [ttam_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ttam_pkg::IDX_W-1:0]      dest_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ttam_pkg::IDX_W-1:0]      source_index,
  output logic                            no_source,
  output logic                            out_of_range
);
  import ttam_pkg::*;

  localparam int SIDE_W = side_w(MAX_SIDE);
  localparam int WB_W   = wb_w(MAX_SIDE);
  localparam int BW_W   = bw_w(MAX_SIDE);
  localparam int RS_W   = rs_w(MAX_SIDE);
  localparam int RP_W   = rp_w(MAX_SIDE);
  localparam int TOT_W  = RP_W + RS_W;
  localparam int PIX_W  = 2 * SIDE_W;

  ttam_mode_t        mode;
  logic [SIDE_W-1:0] h;
  logic [WB_W-1:0]   wb;
  logic [BW_W-1:0]   bw;
  logic [RS_W-1:0]   row_size;
  logic [TOT_W-1:0]  total;
  logic [PIX_W-1:0]  pixels;

  logic              fr_valid;
  logic              div_ready;
  logic [IDX_W-1:0]  fr_numer;
  ttam_side_t        fr_side;

  logic              dv_valid;
  logic              bk_ready;
  logic [RP_W-1:0]   dv_quo;
  logic [BW_W-1:0]   dv_rem;
  ttam_side_t        dv_side;

  ttam_cfg #(.MAX_SIDE(MAX_SIDE)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mode      (mode),
    .h         (h),
    .wb        (wb),
    .bw        (bw),
    .row_size  (row_size),
    .total     (total),
    .pixels    (pixels)
  );

  ttam_front #(.MAX_SIDE(MAX_SIDE)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .dest_index (dest_index),
    .mode       (mode),
    .total      (total),
    .pixels     (pixels),
    .out_valid  (fr_valid),
    .dn_ready   (div_ready),
    .numer      (fr_numer),
    .side       (fr_side)
  );

  ttam_div #(.MAX_SIDE(MAX_SIDE)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (div_ready),
    .numer     (fr_numer),
    .side_in   (fr_side),
    .bw        (bw),
    .out_valid (dv_valid),
    .dn_ready  (bk_ready),
    .quo       (dv_quo),
    .rem       (dv_rem),
    .side_out  (dv_side)
  );

  ttam_back #(.MAX_SIDE(MAX_SIDE)) u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (dv_valid),
    .in_ready     (bk_ready),
    .quo          (dv_quo),
    .rem          (dv_rem),
    .side         (dv_side),
    .mode         (mode),
    .h            (h),
    .wb           (wb),
    .bw           (bw),
    .row_size     (row_size),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .source_index (source_index),
    .no_source    (no_source),
    .out_of_range (out_of_range)
  );

  // Input back-pressure only appears once every stage holds an item.
  a_full_before_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while the pipeline still has room");

  a_oor_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_of_range) |-> (!no_source && source_index == '0))
    else $error("out-of-range item carries a source");

  a_nosrc_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && no_source) |-> (source_index == '0))
    else $error("padding item carries a non-zero source index");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result offered straight after reset");

endmodule
